// ===== sv/cuah_pkg.sv =====
// cuah_pkg: shared types and constants for the channel-use approximate histogram
// no dependencies; used by cuah_mod and channel_use_approx_histogram

package cuah_pkg;

  // fixed field widths
  localparam int CHAN_W = 7;
  localparam int CNT_W  = 8;

  // saturation value of a usage counter
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ===== sv/cuah_ram.sv =====
// cuah_ram: generic simple dual-port RAM, one write port and one registered read port
// no dependencies

module cuah_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cuah_mod.sv =====
// cuah_mod: iterative restoring remainder unit, one dividend bit per cycle
// depends on cuah_pkg

module cuah_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cuah_pkg::CNT_W-1:0] dividend_i,
  input  logic [cuah_pkg::CNT_W-1:0] divisor_i,
  output logic                       done_o,
  output logic                       rem_zero_o
);

  localparam int SW = $clog2(cuah_pkg::CNT_W);

  logic                       run_q, done_q;
  logic [SW-1:0]              step_q;
  logic [cuah_pkg::CNT_W-1:0] dvd_q, div_q, rem_q;
  logic [cuah_pkg::CNT_W:0]   trial;
  logic [cuah_pkg::CNT_W:0]   diff;
  logic                       last_step;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial     = {rem_q, dvd_q[cuah_pkg::CNT_W-1]};
  assign diff      = trial - {1'b0, div_q};
  assign last_step = (step_q == SW'(cuah_pkg::CNT_W - 1));

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= run_q && last_step;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + SW'(1);
        if (last_step) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[cuah_pkg::CNT_W-2:0], 1'b0};
      if (!diff[cuah_pkg::CNT_W]) begin
        rem_q <= diff[cuah_pkg::CNT_W-1:0];
      end else begin
        rem_q <= trial[cuah_pkg::CNT_W-1:0];
      end
    end
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

// ===== sv/channel_use_approx_histogram.sv =====
// channel_use_approx_histogram: top level, per-channel approximate usage counters
// depends on cuah_pkg, cuah_ram, cuah_mod
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o   | channel_i, busy_req_i, random_value_i
//   out     | output    | out_valid_o / out_ready_i | channel_count_o, max_count_o, incremented_o
//
// one request at a time: a request runs the 8-step remainder unit when busy_req_i is set,
// the channel is in range and its counter is 1 to 254, else it goes from read to done
// counters live in one RAM and are read per request and written back when incremented
// after reset a clearing pass writes zero to all NUM_CHANNELS entries, one per cycle,
// and in_ready_o stays low until the pass is done
// the output register lets the next request enter while a result waits

module channel_use_approx_histogram #(
  parameter int NUM_CHANNELS = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cuah_pkg::CHAN_W-1:0] channel_i,
  input  logic                        busy_req_i,
  input  logic [cuah_pkg::CNT_W-1:0]  random_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cuah_pkg::CNT_W-1:0]  channel_count_o,
  output logic [cuah_pkg::CNT_W-1:0]  max_count_o,
  output logic                        incremented_o
);

  localparam int AW   = $clog2(NUM_CHANNELS);
  localparam int CMPW = ((AW > cuah_pkg::CHAN_W) ? AW : cuah_pkg::CHAN_W) + 1;

  cuah_pkg::state_e state_q, state_d;

  logic [AW-1:0]              clr_addr_q;
  logic [AW-1:0]              addr_q;
  logic                       busy_q, in_range_q;
  logic [cuah_pkg::CNT_W-1:0] rnd_q, cnt_q;
  logic [cuah_pkg::CNT_W-1:0] peak_q, peak_d;
  logic                       out_valid_q;
  logic [cuah_pkg::CNT_W-1:0] out_count_q, out_max_q;
  logic                       out_inc_q;

  logic [CMPW-1:0]            chan_ext;
  logic                       in_range;
  logic                       accept;
  logic                       clr_last;
  logic                       out_fire;
  logic                       need_div;
  logic                       inc;
  logic [cuah_pkg::CNT_W-1:0] cnt_inc;
  logic [cuah_pkg::CNT_W-1:0] rdata;
  logic [cuah_pkg::CNT_W-1:0] cnt_rd;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr;
  logic [cuah_pkg::CNT_W-1:0] ram_wdata;
  logic                       mod_start, mod_done, rem_zero;

  // channel range check and address
  assign chan_ext = CMPW'(channel_i);
  assign in_range = (chan_ext < CMPW'(NUM_CHANNELS));
  assign accept   = in_valid_i && in_ready_o;
  assign clr_last = (clr_addr_q == AW'(NUM_CHANNELS - 1));

  // counter read back, forced to zero for a channel out of range
  assign cnt_rd   = in_range_q ? rdata : '0;
  assign need_div = busy_q && in_range_q && (rdata != '0) && (rdata != cuah_pkg::CNT_MAX);

  // increment decision and new maximum
  assign inc      = busy_q && in_range_q && (cnt_q != cuah_pkg::CNT_MAX)
                    && ((cnt_q == '0) || rem_zero);
  assign cnt_inc  = cnt_q + cuah_pkg::CNT_W'(1);
  assign peak_d   = (inc && (cnt_inc > peak_q)) ? peak_q + cuah_pkg::CNT_W'(1) : peak_q;
  assign out_fire = (state_q == cuah_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cuah_pkg::ST_CLEAR: if (clr_last) state_d = cuah_pkg::ST_IDLE;
      cuah_pkg::ST_IDLE:  if (in_valid_i) state_d = cuah_pkg::ST_READ;
      cuah_pkg::ST_READ:  state_d = need_div ? cuah_pkg::ST_DIV : cuah_pkg::ST_DONE;
      cuah_pkg::ST_DIV:   if (mod_done) state_d = cuah_pkg::ST_DONE;
      cuah_pkg::ST_DONE:  if (out_fire) state_d = cuah_pkg::ST_IDLE;
      default:            state_d = cuah_pkg::ST_CLEAR;
    endcase
  end

  // state outputs: handshake, RAM ports, remainder start
  always_comb begin
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = cnt_inc;
    mod_start  = 1'b0;
    unique case (state_q)
      cuah_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      cuah_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_re     = in_valid_i;
      end
      cuah_pkg::ST_READ: begin
        mod_start = need_div;
      end
      cuah_pkg::ST_DIV: begin
      end
      cuah_pkg::ST_DONE: begin
        ram_we = out_fire && inc;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cuah_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_fire || (out_valid_q && !out_ready_i);
      if (state_q == cuah_pkg::ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (out_fire) begin
        peak_q <= peak_d;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q     <= chan_ext[AW-1:0];
      busy_q     <= busy_req_i;
      in_range_q <= in_range;
      rnd_q      <= random_value_i;
    end
    if (state_q == cuah_pkg::ST_READ) begin
      cnt_q <= cnt_rd;
    end
    if (out_fire) begin
      out_count_q <= inc ? cnt_inc : cnt_q;
      out_max_q   <= peak_d;
      out_inc_q   <= inc;
    end
  end

  // counter store
  cuah_ram #(
    .WIDTH (cuah_pkg::CNT_W),
    .DEPTH (NUM_CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (chan_ext[AW-1:0]),
    .rdata_o (rdata)
  );

  // random byte modulo current counter
  cuah_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rnd_q),
    .divisor_i  (rdata),
    .done_o     (mod_done),
    .rem_zero_o (rem_zero)
  );

  assign out_valid_o     = out_valid_q;
  assign channel_count_o = out_count_q;
  assign max_count_o     = out_max_q;
  assign incremented_o   = out_inc_q;

endmodule
